// ----- rtl/rli_pkg.sv -----
// Shared widths, codes and transaction types for the ray/line intersection block.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package rli_pkg;

	// Coordinate, difference and product widths
	localparam int CW = 16;          // Q12.4 coordinate
	localparam int DW = CW + 1;      // difference of two coordinates
	localparam int PW = 2 * DW;      // cross-product terms, denominator, numerators
	localparam int OW = PW + CW;     // origin times denominator
	localparam int SW = PW + DW;     // s numerator times direction
	localparam int NW = SW + 1;      // coordinate numerator before division
	localparam int QB = CW + 1;      // quotient magnitude bits

	// Decoupling queue depth
	localparam int FQ_DEPTH = 4;

	// Register port address width and register indexes
	localparam int AW = 4;
	localparam logic [AW-3:0] REG_ORIGIN_X  = 2'd0;
	localparam logic [AW-3:0] REG_ORIGIN_Y  = 2'd1;
	localparam logic [AW-3:0] REG_THROUGH_X = 2'd2;
	localparam logic [AW-3:0] REG_THROUGH_Y = 2'd3;

	// Query kinds
	localparam logic [1:0] OP_LINE = 2'd0;
	localparam logic [1:0] OP_RAY  = 2'd1;
	localparam logic [1:0] OP_SEG  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t through_x;
		coord_t through_y;
	} ray_cfg_t;

	// Classified query waiting for the division back end
	typedef struct packed {
		logic                 hit;
		logic signed [NW-1:0] num_x;
		logic signed [NW-1:0] num_y;
		logic [PW-1:0]        den;
	} rli_item_t;

endpackage

`default_nettype wire

// ----- rtl/rli_chan_if.sv -----
// Valid/ready channel interfaces for query and result transactions.
// Depends on rli_pkg for the coordinate width.
`default_nettype none

interface rli_query_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic signed [rli_pkg::CW-1:0] query_c_x;
	logic signed [rli_pkg::CW-1:0] query_c_y;
	logic signed [rli_pkg::CW-1:0] query_d_x;
	logic signed [rli_pkg::CW-1:0] query_d_y;

	modport source (
		output valid, operation, query_c_x, query_c_y, query_d_x, query_d_y,
		input  ready
	);
	modport sink (
		input  valid, operation, query_c_x, query_c_y, query_d_x, query_d_y,
		output ready
	);
endinterface

interface rli_result_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [rli_pkg::CW-1:0] hit_x;
	logic signed [rli_pkg::CW-1:0] hit_y;
	logic                          clipped;

	modport source (
		output valid, hit, hit_x, hit_y, clipped,
		input  ready
	);
	modport sink (
		input  valid, hit, hit_x, hit_y, clipped,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/ray_line_intersection.sv -----
// Top level: register port for the ray, front end, queue and division back end.
// Depends on rli_pkg, rli_chan_if, rli_front, rli_fifo and rli_back.
//
//   channel  direction  handshake            payload
//   qry      in         valid/ready          operation, query_c_x/y, query_d_x/y
//   res      out        valid/ready          hit, hit_x, hit_y, clipped
//   apb      in         psel/penable/pready  paddr, pwdata, prdata
//
// One query per cycle while results are taken; a query passes 6 front stages,
// the queue and 19 back stages, set by a 17-step restoring divider per coordinate.
// Reset clears the ray registers to zero and empties every stage and the queue.
// A stalled result freezes the back end; the 4-entry queue keeps the front
// moving until it fills, then qry.ready drops once stage 6 holds a query.
`default_nettype none

module ray_line_intersection #(
	parameter int COORD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [rli_pkg::AW-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	rli_query_if.sink              qry,
	rli_result_if.source           res
);

	rli_pkg::ray_cfg_t         cfg_q;
	rli_pkg::coord_t           rd_val;
	logic                      wr_en;
	logic [rli_pkg::AW-3:0]    reg_idx;

	logic                      q_push, q_full, q_valid, q_pop;
	rli_pkg::rli_item_t        q_wr_item, q_rd_item;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[rli_pkg::AW-1:2];

	// Write ray registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				rli_pkg::REG_ORIGIN_X:  cfg_q.origin_x  <= pwdata[rli_pkg::CW-1:0];
				rli_pkg::REG_ORIGIN_Y:  cfg_q.origin_y  <= pwdata[rli_pkg::CW-1:0];
				rli_pkg::REG_THROUGH_X: cfg_q.through_x <= pwdata[rli_pkg::CW-1:0];
				rli_pkg::REG_THROUGH_Y: cfg_q.through_y <= pwdata[rli_pkg::CW-1:0];
				default: ;
			endcase
		end
	end

	// Read back, sign extended
	always_comb begin
		case (reg_idx)
			rli_pkg::REG_ORIGIN_X:  rd_val = cfg_q.origin_x;
			rli_pkg::REG_ORIGIN_Y:  rd_val = cfg_q.origin_y;
			rli_pkg::REG_THROUGH_X: rd_val = cfg_q.through_x;
			rli_pkg::REG_THROUGH_Y: rd_val = cfg_q.through_y;
			default:                rd_val = '0;
		endcase
	end
	assign prdata = 32'(rd_val);

	rli_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.qry    (qry),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_wr_item)
	);

	rli_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.valid   (q_valid),
		.pop     (q_pop),
		.rd_item (q_rd_item)
	);

	rli_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_rd_item),
		.q_pop   (q_pop),
		.res     (res)
	);

`ifndef SYNTHESIS
	// Front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue push while full");

	// A miss carries zero coordinates and no clip flag
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.hit) |-> (res.hit_x == '0 && res.hit_y == '0 && !res.clipped))
		else $error("miss result with nonzero payload");

	// The back end never pops an empty queue into a valid stage
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/rli_front.sv -----
// Front end: accepts queries, forms cross products, classifies the hit and
// builds the coordinate numerators. Depends on rli_pkg and rli_query_if.
`default_nettype none

module rli_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rli_pkg::ray_cfg_t   cfg,
	rli_query_if.sink           qry,
	input  logic                q_full,
	output logic                q_push,
	output rli_pkg::rli_item_t  q_item
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: differences
	logic [1:0]                    mode_s1;
	logic signed [rli_pkg::CW-1:0] ox_s1, oy_s1;
	logic signed [rli_pkg::DW-1:0] xab_s1, yab_s1, xcd_s1, ycd_s1, xac_s1, yac_s1;

	// Stage 2: products
	logic [1:0]                    mode_s2;
	logic signed [rli_pkg::CW-1:0] ox_s2, oy_s2;
	logic signed [rli_pkg::DW-1:0] xab_s2, yab_s2;
	logic signed [rli_pkg::PW-1:0] pd1_s2, pd2_s2, ps1_s2, ps2_s2, pt1_s2, pt2_s2;

	// Stage 3: denominator and numerators
	logic [1:0]                    mode_s3;
	logic signed [rli_pkg::CW-1:0] ox_s3, oy_s3;
	logic signed [rli_pkg::DW-1:0] xab_s3, yab_s3;
	logic signed [rli_pkg::PW-1:0] den_s3, ns_s3, nt_s3;

	// Stage 4: sign normalized
	logic [1:0]                    mode_s4;
	logic                          drop_s4;
	logic signed [rli_pkg::CW-1:0] ox_s4, oy_s4;
	logic signed [rli_pkg::DW-1:0] xab_s4, yab_s4;
	logic signed [rli_pkg::PW-1:0] den_s4, ns_s4, nt_s4;

	// Stage 5: classified, coordinate products
	logic                          hit_s5;
	logic [rli_pkg::PW-1:0]        den_s5;
	logic signed [rli_pkg::OW-1:0] pox_s5, poy_s5;
	logic signed [rli_pkg::SW-1:0] psx_s5, psy_s5;

	// Stage 6: coordinate numerators
	logic                          hit_s6;
	logic [rli_pkg::PW-1:0]        den_s6;
	logic signed [rli_pkg::NW-1:0] nx_s6, ny_s6;

	logic neg_den;
	logic ray_ok, seg_ok;

	// Advance the whole front while the last stage is empty or the queue has room
	assign en        = !v_s6 || !q_full;
	assign qry.ready = en;
	assign q_push    = v_s6 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= qry.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Sign term for stage 4 and classification terms for stage 5
	assign neg_den = den_s3[rli_pkg::PW-1];
	assign ray_ok  = !((mode_s4 == rli_pkg::OP_RAY) && nt_s4[rli_pkg::PW-1]);
	assign seg_ok  = !((mode_s4 == rli_pkg::OP_SEG) &&
	                   (nt_s4[rli_pkg::PW-1] || (nt_s4 > den_s4)));

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1
			mode_s1 <= qry.operation;
			ox_s1   <= cfg.origin_x;
			oy_s1   <= cfg.origin_y;
			xab_s1  <= rli_pkg::DW'(cfg.through_x) - rli_pkg::DW'(cfg.origin_x);
			yab_s1  <= rli_pkg::DW'(cfg.through_y) - rli_pkg::DW'(cfg.origin_y);
			xcd_s1  <= rli_pkg::DW'(qry.query_d_x) - rli_pkg::DW'(qry.query_c_x);
			ycd_s1  <= rli_pkg::DW'(qry.query_d_y) - rli_pkg::DW'(qry.query_c_y);
			xac_s1  <= rli_pkg::DW'(qry.query_c_x) - rli_pkg::DW'(cfg.origin_x);
			yac_s1  <= rli_pkg::DW'(qry.query_c_y) - rli_pkg::DW'(cfg.origin_y);

			// Stage 2
			mode_s2 <= mode_s1;
			ox_s2   <= ox_s1;
			oy_s2   <= oy_s1;
			xab_s2  <= xab_s1;
			yab_s2  <= yab_s1;
			pd1_s2  <= rli_pkg::PW'(xcd_s1) * rli_pkg::PW'(yab_s1);
			pd2_s2  <= rli_pkg::PW'(xab_s1) * rli_pkg::PW'(ycd_s1);
			ps1_s2  <= rli_pkg::PW'(xcd_s1) * rli_pkg::PW'(yac_s1);
			ps2_s2  <= rli_pkg::PW'(xac_s1) * rli_pkg::PW'(ycd_s1);
			pt1_s2  <= rli_pkg::PW'(xab_s1) * rli_pkg::PW'(yac_s1);
			pt2_s2  <= rli_pkg::PW'(xac_s1) * rli_pkg::PW'(yab_s1);

			// Stage 3
			mode_s3 <= mode_s2;
			ox_s3   <= ox_s2;
			oy_s3   <= oy_s2;
			xab_s3  <= xab_s2;
			yab_s3  <= yab_s2;
			den_s3  <= pd1_s2 - pd2_s2;
			ns_s3   <= ps1_s2 - ps2_s2;
			nt_s3   <= pt1_s2 - pt2_s2;

			// Stage 4: make the denominator positive, drop parallel or unused
			mode_s4 <= mode_s3;
			ox_s4   <= ox_s3;
			oy_s4   <= oy_s3;
			xab_s4  <= xab_s3;
			yab_s4  <= yab_s3;
			den_s4  <= neg_den ? -den_s3 : den_s3;
			ns_s4   <= neg_den ? -ns_s3 : ns_s3;
			nt_s4   <= neg_den ? -nt_s3 : nt_s3;
			drop_s4 <= (mode_s3 == rli_pkg::OP_NONE) || (den_s3 == '0);

			// Stage 5: hit test and coordinate products
			hit_s5 <= !drop_s4 && !ns_s4[rli_pkg::PW-1] && ray_ok && seg_ok;
			den_s5 <= den_s4;
			pox_s5 <= rli_pkg::OW'(ox_s4) * rli_pkg::OW'(den_s4);
			poy_s5 <= rli_pkg::OW'(oy_s4) * rli_pkg::OW'(den_s4);
			psx_s5 <= rli_pkg::SW'(ns_s4) * rli_pkg::SW'(xab_s4);
			psy_s5 <= rli_pkg::SW'(ns_s4) * rli_pkg::SW'(yab_s4);

			// Stage 6: numerators
			hit_s6 <= hit_s5;
			den_s6 <= den_s5;
			nx_s6  <= rli_pkg::NW'(pox_s5) + rli_pkg::NW'(psx_s5);
			ny_s6  <= rli_pkg::NW'(poy_s5) + rli_pkg::NW'(psy_s5);
		end
	end

	assign q_item.hit   = hit_s6;
	assign q_item.num_x = nx_s6;
	assign q_item.num_y = ny_s6;
	assign q_item.den   = den_s6;

endmodule

`default_nettype wire

// ----- rtl/rli_fifo.sv -----
// Short queue between the front end and the division back end.
// Depends on rli_pkg for the item type and depth.
`default_nettype none

module rli_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rli_pkg::rli_item_t wr_item,
	output logic               full,
	output logic               valid,
	input  logic               pop,
	output rli_pkg::rli_item_t rd_item
);

	localparam int PTR = $clog2(rli_pkg::FQ_DEPTH);

	rli_pkg::rli_item_t mem_q [rli_pkg::FQ_DEPTH];
	logic [PTR-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PTR:0]       cnt_q;
	logic               do_pop;

	assign full    = (cnt_q == (PTR+1)'(rli_pkg::FQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_pop  = pop && valid;
	assign rd_item = mem_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR+1)'(push) - (PTR+1)'(do_pop);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rli_div.sv -----
// Pipelined restoring divider: magnitude of a signed numerator over a positive
// denominator, one quotient bit per stage with an overflow flag. Depends on rli_pkg.
`default_nettype none

module rli_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [rli_pkg::NW-1:0] num,
	input  logic [rli_pkg::PW-1:0]        den,
	output logic [rli_pkg::QB-1:0]        quo,
	output logic                          neg,
	output logic                          ovf
);

	localparam int QB = rli_pkg::QB;
	localparam int NW = rli_pkg::NW;

	logic [NW-1:0]           rem_s [0:QB];
	logic [rli_pkg::PW-1:0]  den_s [0:QB];
	logic [QB-1:0]           quo_s [0:QB];
	logic                    neg_s [0:QB];
	logic                    ovf_s [1:QB];

	logic [NW-1:0]           trial_d [1:QB];
	logic                    ge_d    [1:QB];
	logic [NW-1:0]           rem_d   [1:QB];
	logic [QB-1:0]           quo_d   [1:QB];
	logic                    ovf_d;

	// One trial subtraction per stage
	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			trial_d[k] = NW'(den_s[k-1]) << (QB - k);
			ge_d[k]    = (rem_s[k-1] >= trial_d[k]);
			rem_d[k]   = ge_d[k] ? (rem_s[k-1] - trial_d[k]) : rem_s[k-1];
			quo_d[k]   = quo_s[k-1] | (ge_d[k] ? (QB'(1) << (QB - k)) : '0);
		end
	end

	// Quotient does not fit in QB bits
	assign ovf_d = (rem_s[0] >= (NW'(den_s[0]) << QB));

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num[NW-1] ? NW'(-num) : NW'(num);
			neg_s[0] <= num[NW-1];
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[1] <= ovf_d;
			for (int k = 1; k <= QB; k++) begin
				rem_s[k] <= rem_d[k];
				quo_s[k] <= quo_d[k];
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
			for (int k = 2; k <= QB; k++) begin
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[QB];
	assign neg = neg_s[QB];
	assign ovf = ovf_s[QB];

endmodule

`default_nettype wire

// ----- rtl/rli_back.sv -----
// Back end: divides both coordinate numerators, saturates and holds the result
// in the output register. Depends on rli_pkg, rli_div and rli_result_if.
`default_nettype none

module rli_back #(
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  rli_pkg::rli_item_t q_item,
	output logic               q_pop,
	rli_result_if.source       res
);

	localparam int CW = rli_pkg::CW;
	localparam int QB = rli_pkg::QB;
	localparam int EB = (COORD_BITS > CW) ? CW : COORD_BITS;
	localparam logic [QB-1:0]        POS_MAX = QB'((1 << (EB - 1)) - 1);
	localparam logic [QB-1:0]        NEG_MAX = QB'(1 << (EB - 1));
	localparam logic signed [CW-1:0] HI      = CW'((1 << (EB - 1)) - 1);
	localparam logic signed [CW-1:0] LO      = CW'(-(1 << (EB - 1)));

	typedef struct packed {
		logic signed [CW-1:0] val;
		logic                 sat;
	} clamp_t;

	function automatic clamp_t clamp(input logic [QB-1:0] q, input logic n,
	                                 input logic o);
		clamp_t r;
		r.sat = o || (n ? (q > NEG_MAX) : (q > POS_MAX));
		if (r.sat) begin
			r.val = n ? LO : HI;
		end else begin
			r.val = n ? -CW'(q) : CW'(q);
		end
		return r;
	endfunction

	logic                 en;
	logic                 vld_s [0:QB];
	logic                 hit_s [0:QB];
	logic [QB-1:0]        quo_x, quo_y;
	logic                 neg_x, neg_y, ovf_x, ovf_y;
	clamp_t               cx, cy;
	logic                 valid_q, hit_q, clipped_q;
	logic signed [CW-1:0] hit_x_q, hit_y_q;

	// Advance while the output register is empty or being taken
	assign en    = !valid_q || res.ready;
	assign q_pop = q_valid && en;

	rli_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (q_item.num_x),
		.den (q_item.den),
		.quo (quo_x),
		.neg (neg_x),
		.ovf (ovf_x)
	);

	rli_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (q_item.num_y),
		.den (q_item.den),
		.quo (quo_y),
		.neg (neg_y),
		.ovf (ovf_y)
	);

	// Track occupancy alongside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
			valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= q_valid;
			for (int k = 1; k <= QB; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			valid_q <= vld_s[QB];
		end
	end

	assign cx = clamp(quo_x, neg_x, ovf_x);
	assign cy = clamp(quo_y, neg_y, ovf_y);

	// Carry the hit flag and load the output register
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s[0] <= q_item.hit;
			for (int k = 1; k <= QB; k++) begin
				hit_s[k] <= hit_s[k-1];
			end
			hit_q <= hit_s[QB];
			if (hit_s[QB]) begin
				hit_x_q   <= cx.val;
				hit_y_q   <= cy.val;
				clipped_q <= cx.sat || cy.sat;
			end else begin
				hit_x_q   <= '0;
				hit_y_q   <= '0;
				clipped_q <= 1'b0;
			end
		end
	end

	assign res.valid   = valid_q;
	assign res.hit     = hit_q;
	assign res.hit_x   = hit_x_q;
	assign res.hit_y   = hit_y_q;
	assign res.clipped = clipped_q;

endmodule

`default_nettype wire
